[sv/ssvg_pkg.sv]
// Shared types and constants for the sphere strip vertex generator.
// No dependencies; every other file refers to it by scoped names.
package ssvg_pkg;

  localparam int IDX_W       = 19;
  localparam int COORD_W     = 16;
  localparam int BAND_W      = 4;
  localparam logic [BAND_W-1:0] BAND_RESET = 4'd5;
  localparam int BAND_MIN    = 3;
  localparam int PHASE_W     = 32;
  localparam int DIV_BITS    = 4;                 // quotient bits per divider stage
  localparam int DIV_STAGES  = PHASE_W / DIV_BITS;
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_PER  = 2;                 // rotations per pipeline stage
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;
  localparam int CORDIC_W    = 34;
  localparam int TRIG_W      = 32;
  localparam int PROD_W      = 64;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_START = 34'sd652032874;

  // quadrant codes, top two phase bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // arctangent of 2^-k in 2^-32 turn units
  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
    34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5
  };

  typedef struct packed {
    logic valid;
    logic in_range;
  } ctl_t;

endpackage

[sv/sphere_strip_vertex_generator_core.sv]
// Sphere strip vertex generator, top level.
// Instantiates ssvg_divider, ssvg_cordic, ssvg_coord; uses ssvg_pkg.
//
// Usage:
//  - Input stream s_*: one beat = one vertex index (s_tdata[18:0]).
//  - Output stream m_*: one beat per input beat, same order: x, y, z in signed
//    Q1.(COORD_FRAC_BITS) and an index_valid flag.
//  - cfg_we/cfg_wdata write the band power (log2 points per band, resets to 5);
//    values below 3 act as 3, above MAX_BAND_POWER as MAX_BAND_POWER.
//    Write only when the pipe is empty.
//  - Pipeline: 26 register stages: 1 index decode stage, 8 divider stages
//    (4 quotient bits each), 14 CORDIC stages (2 rotations each), 3 stages for
//    quadrant fold, multiply and rounding.
//  - Throughput: one beat per cycle unless stalled; stages are register slices.
//  - Stall: all stages share one enable. When m_tvalid is high and m_tready
//    low the whole pipe freezes and s_tready drops; nothing is lost or doubled.
//    Bubbles inside the pipe are not squeezed out during a stall.
//  - Reset (rst, sync): clears all stage valid bits, holds s_tready low and
//    sets the band power back to 5.
//  - An index past the end of the strip gives index_valid = 0 and zero coords.
module sphere_strip_vertex_generator_core #(
  parameter int MAX_BAND_POWER  = 10,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  // slave stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,   // [18:0] vertex_index
  // master stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [55:0]                  m_tdata,   // [15:0] pos_x, [31:16] pos_y,
                                                  // [47:32] pos_z, [48] index_valid
  // configuration
  input  logic                         cfg_we,
  input  logic [ssvg_pkg::BAND_W-1:0]  cfg_wdata
);

  localparam int SEC_W = MAX_BAND_POWER - 1;
  localparam int BW    = ssvg_pkg::BAND_W;
  localparam int IW    = ssvg_pkg::IDX_W;

  logic [BW-1:0]    band_log2;
  logic [BW-1:0]    n_eff;
  logic [SEC_W-1:0] sec;
  logic [31:0]      strip_len;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    band;
  logic [SEC_W-1:0] p_next, hx, h_next;
  logic             in_range;
  logic             en;

  logic [SEC_W-1:0]  p_r, h_r;
  ssvg_pkg::ctl_t    ctl0, ctl_div, ctl_cor, ctl_out;
  logic [1:0][SEC_W-1:0]                 num;
  logic [1:0][ssvg_pkg::PHASE_W-1:0]     phase;
  logic [1:0][ssvg_pkg::CORDIC_W-1:0]    cx, cy;
  logic [1:0][1:0]                       cq;
  logic [ssvg_pkg::COORD_W-1:0]          pos_x, pos_y, pos_z;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      band_log2 <= ssvg_pkg::BAND_RESET;
    end else if (cfg_we) begin
      band_log2 <= cfg_wdata;
    end
  end

  // clamp band power and derive points per half band
  always_comb begin
    if (32'(band_log2) < ssvg_pkg::BAND_MIN) begin
      n_eff = BW'(ssvg_pkg::BAND_MIN);
    end else if (32'(band_log2) > MAX_BAND_POWER) begin
      n_eff = BW'(MAX_BAND_POWER);
    end else begin
      n_eff = band_log2;
    end
  end

  assign sec       = SEC_W'((32'd1 << (n_eff - 1'b1)) - 32'd1);
  assign strip_len = 32'(sec) << n_eff;

  // index decode: pitch steps and heading steps (mod sec)
  assign idx      = s_tdata[IW-1:0];
  assign in_range = 32'(idx) < strip_len;
  assign band     = idx >> n_eff;
  assign p_next   = SEC_W'(band) + SEC_W'(idx[0]);
  assign hx       = SEC_W'(idx >> 1) & sec;
  assign h_next   = (hx == sec) ? '0 : hx;

  // single enable: advance unless the output beat is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else if (en) begin
      ctl0.valid    <= s_tvalid;
      ctl0.in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_next;
      h_r <= h_next;
    end
  end

  // pitch phase = p*2^31/sec = p*2^32/(2 sec); heading phase = h*2^32/sec
  assign num[0] = p_r;
  assign num[1] = h_r;

  ssvg_divider #(.SEC_W(SEC_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .sec     (sec),
    .in_ctl  (ctl0),
    .num     (num),
    .out_ctl (ctl_div),
    .phase   (phase)
  );

  ssvg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (ctl_div),
    .phase   (phase),
    .out_ctl (ctl_cor),
    .xo      (cx),
    .yo      (cy),
    .quad    (cq)
  );

  ssvg_coord #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_coord (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (ctl_cor),
    .xi      (cx),
    .yi      (cy),
    .quad    (cq),
    .out_ctl (ctl_out),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z)
  );

  assign m_tvalid = ctl_out.valid;
  assign m_tdata  = {7'd0, ctl_out.in_range, pos_z, pos_y, pos_x};

  // out-of-range beats carry zero coordinates
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[48] |-> m_tdata[47:0] == 48'd0)
    else $error("out-of-range beat with nonzero coordinates");

  // a stuck output beat must block the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // z stays within unit magnitude when it fits the field
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (COORD_FRAC_BITS > 14) ||
      (($signed(m_tdata[47:32]) <= (32'sd1 <<< COORD_FRAC_BITS)) &&
       ($signed(m_tdata[47:32]) >= -(32'sd1 <<< COORD_FRAC_BITS))))
    else $error("pos_z out of range");

  // a stalled pipe keeps its output beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed during stall");

endmodule

[sv/ssvg_divider.sv]
// Pipelined restoring divider: phase = floor(num * 2^32 / den), two lanes.
// Lane 0 divides by 2*sec, lane 1 by sec. Depends on ssvg_pkg.
module ssvg_divider #(
  parameter int SEC_W = 9
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic [SEC_W-1:0]                        sec,
  input  ssvg_pkg::ctl_t                          in_ctl,
  input  logic [1:0][SEC_W-1:0]                   num,
  output ssvg_pkg::ctl_t                          out_ctl,
  output logic [1:0][ssvg_pkg::PHASE_W-1:0]       phase
);

  localparam int ST = ssvg_pkg::DIV_STAGES;
  localparam int PW = ssvg_pkg::PHASE_W;

  // remainder is one bit wider than sec: lane 0 keeps values below 2*sec
  logic [SEC_W:0]   rem_r [ST][2];
  logic [PW-1:0]    quo_r [ST][2];
  ssvg_pkg::ctl_t   ctl_r [ST];

  genvar s, l;
  generate
    for (s = 0; s < ST; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_r[s] <= '0;
        end else if (en) begin
          ctl_r[s] <= (s == 0) ? in_ctl : ctl_r[(s == 0) ? 0 : s-1];
        end
      end
      for (l = 0; l < 2; l++) begin : g_lane
        logic [SEC_W:0]   rem_in;
        logic [PW-1:0]    quo_in;
        logic [SEC_W:0]   rem_next;
        logic [PW-1:0]    quo_next;
        logic [SEC_W:0]   den;

        assign rem_in = (s == 0) ? {1'b0, num[l]} : rem_r[(s == 0) ? 0 : s-1][l];
        assign quo_in = (s == 0) ? '0 : quo_r[(s == 0) ? 0 : s-1][l];
        assign den    = (l == 0) ? {sec, 1'b0} : {1'b0, sec};

        always_comb begin : b_step
          logic [SEC_W+1:0] t;
          rem_next = rem_in;
          quo_next = quo_in;
          for (int b = 0; b < ssvg_pkg::DIV_BITS; b++) begin
            t = {rem_next, 1'b0};
            if (t >= {1'b0, den}) begin
              t = t - {1'b0, den};
              quo_next = {quo_next[PW-2:0], 1'b1};
            end else begin
              quo_next = {quo_next[PW-2:0], 1'b0};
            end
            rem_next = t[SEC_W:0];
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s][l] <= rem_next;
            quo_r[s][l] <= quo_next;
          end
        end

        if (s == ST-1) begin : g_out
          assign phase[l] = quo_r[s][l];
        end
      end
    end
  endgenerate

  assign out_ctl = ctl_r[ST-1];

endmodule

[sv/ssvg_cordic.sv]
// Pipelined rotation-mode CORDIC, two lanes, two rotations per stage.
// Outputs first-quadrant x (cos) and y (sin) at scale 2^30 plus quadrant. Uses ssvg_pkg.
module ssvg_cordic (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  ssvg_pkg::ctl_t                            in_ctl,
  input  logic [1:0][ssvg_pkg::PHASE_W-1:0]         phase,
  output ssvg_pkg::ctl_t                            out_ctl,
  output logic [1:0][ssvg_pkg::CORDIC_W-1:0]        xo,
  output logic [1:0][ssvg_pkg::CORDIC_W-1:0]        yo,
  output logic [1:0][1:0]                           quad
);

  localparam int ST = ssvg_pkg::CORDIC_STAGES;
  localparam int CW = ssvg_pkg::CORDIC_W;
  localparam int PW = ssvg_pkg::PHASE_W;

  logic signed [CW-1:0] x_r [ST][2];
  logic signed [CW-1:0] y_r [ST][2];
  logic signed [CW-1:0] z_r [ST][2];
  logic [1:0]           q_r [ST][2];
  ssvg_pkg::ctl_t       ctl_r [ST];

  genvar s, l;
  generate
    for (s = 0; s < ST; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_r[s] <= '0;
        end else if (en) begin
          ctl_r[s] <= (s == 0) ? in_ctl : ctl_r[(s == 0) ? 0 : s-1];
        end
      end
      for (l = 0; l < 2; l++) begin : g_lane
        logic signed [CW-1:0] x_in, y_in, z_in;
        logic [1:0]           q_in;
        logic signed [CW-1:0] x_next, y_next, z_next;

        assign x_in = (s == 0) ? ssvg_pkg::CORDIC_GAIN_START : x_r[(s == 0) ? 0 : s-1][l];
        assign y_in = (s == 0) ? '0 : y_r[(s == 0) ? 0 : s-1][l];
        assign z_in = (s == 0) ? $signed({{(CW-PW+2){1'b0}}, phase[l][PW-3:0]})
                               : z_r[(s == 0) ? 0 : s-1][l];
        assign q_in = (s == 0) ? phase[l][PW-1:PW-2] : q_r[(s == 0) ? 0 : s-1][l];

        always_comb begin : b_rot
          logic signed [CW-1:0] dx, dy;
          x_next = x_in;
          y_next = y_in;
          z_next = z_in;
          for (int j = 0; j < ssvg_pkg::CORDIC_PER; j++) begin
            dx = y_next >>> (s * ssvg_pkg::CORDIC_PER + j);
            dy = x_next >>> (s * ssvg_pkg::CORDIC_PER + j);
            if (z_next >= 0) begin
              x_next = x_next - dx;
              y_next = y_next + dy;
              z_next = z_next - ssvg_pkg::ATAN_TURNS[s * ssvg_pkg::CORDIC_PER + j];
            end else begin
              x_next = x_next + dx;
              y_next = y_next - dy;
              z_next = z_next + ssvg_pkg::ATAN_TURNS[s * ssvg_pkg::CORDIC_PER + j];
            end
          end
        end

        always_ff @(posedge clk) begin
          if (en) begin
            x_r[s][l] <= x_next;
            y_r[s][l] <= y_next;
            z_r[s][l] <= z_next;
            q_r[s][l] <= q_in;
          end
        end

        if (s == ST-1) begin : g_out
          assign xo[l]   = x_r[s][l];
          assign yo[l]   = y_r[s][l];
          assign quad[l] = q_r[s][l];
        end
      end
    end
  endgenerate

  assign out_ctl = ctl_r[ST-1];

endmodule

[sv/ssvg_coord.sv]
// Quadrant fold, products and rounding to fixed-point coordinates (three stages).
// Lane 0 is pitch, lane 1 heading. Uses ssvg_pkg.
module ssvg_coord #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  ssvg_pkg::ctl_t                        in_ctl,
  input  logic [1:0][ssvg_pkg::CORDIC_W-1:0]    xi,
  input  logic [1:0][ssvg_pkg::CORDIC_W-1:0]    yi,
  input  logic [1:0][1:0]                       quad,
  output ssvg_pkg::ctl_t                        out_ctl,
  output logic [ssvg_pkg::COORD_W-1:0]          pos_x,
  output logic [ssvg_pkg::COORD_W-1:0]          pos_y,
  output logic [ssvg_pkg::COORD_W-1:0]          pos_z
);

  localparam int TW = ssvg_pkg::TRIG_W;
  localparam int PR = ssvg_pkg::PROD_W;
  localparam int CW = ssvg_pkg::CORDIC_W;
  localparam int SH = 60 - COORD_FRAC_BITS;
  localparam logic signed [PR-1:0] HALF = 64'sd1 <<< (SH - 1);
  localparam logic signed [PR-1:0] LIM  = 64'sd1 <<< COORD_FRAC_BITS;

  ssvg_pkg::ctl_t       ctl_a, ctl_b, ctl_c;
  logic signed [TW-1:0] cos_a [2];
  logic signed [TW-1:0] sin_a [2];
  logic signed [PR-1:0] px_b, py_b, pz_b;

  function automatic logic [ssvg_pkg::COORD_W-1:0] to_coord(input logic signed [PR-1:0] p);
    logic signed [PR-1:0] v;
    logic signed [PR-1:0] r;
    v = -p;
    r = (v + HALF) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[ssvg_pkg::COORD_W-1:0];
  endfunction

  // stage A: fold the quadrant back in
  genvar l;
  generate
    for (l = 0; l < 2; l++) begin : g_fold
      logic signed [CW-1:0] c_next, s_next, xs, ys;
      assign xs = $signed(xi[l]);
      assign ys = $signed(yi[l]);
      always_comb begin
        case (quad[l])
          ssvg_pkg::QUAD_0: begin c_next = xs;  s_next = ys;  end
          ssvg_pkg::QUAD_1: begin c_next = -ys; s_next = xs;  end
          ssvg_pkg::QUAD_2: begin c_next = -xs; s_next = -ys; end
          default:          begin c_next = ys;  s_next = -xs; end
        endcase
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cos_a[l] <= c_next[TW-1:0];
          sin_a[l] <= s_next[TW-1:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_c <= '0;
    end else if (en) begin
      ctl_a <= in_ctl;
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  // stage B: one 32x32 product each for x and y; z is the pitch cosine shifted left by 30
  always_ff @(posedge clk) begin
    if (en) begin
      px_b <= sin_a[0] * sin_a[1];
      py_b <= sin_a[0] * cos_a[1];
      pz_b <= PR'(cos_a[0]) <<< 30;
    end
  end

  // stage C: negate, round, clamp, zero out-of-range indexes
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= ctl_b.in_range ? to_coord(px_b) : '0;
      pos_y <= ctl_b.in_range ? to_coord(py_b) : '0;
      pos_z <= ctl_b.in_range ? to_coord(pz_b) : '0;
    end
  end

  assign out_ctl = ctl_c;

endmodule
